// ===== design/sds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

  localparam int WordW = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } sds_cmd_e;

  localparam logic [1:0] STACK_LO = 2'd1;
  localparam logic [1:0] STACK_HI = 2'd2;

  // Decoded operation carried from the front end to the back end.
  typedef enum logic [2:0] {
    ACT_REJECT  = 3'd0,
    ACT_PUSH_LO = 3'd1,
    ACT_PUSH_HI = 3'd2,
    ACT_POP_LO  = 3'd3,
    ACT_POP_HI  = 3'd4
  } sds_act_e;

  typedef struct packed {
    sds_act_e         act;
    logic [WordW-1:0] value;
  } sds_item_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RESP = 2'b10
  } sds_bk_state_e;

endpackage

`default_nettype wire

// ===== design/sds_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sds_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         stack_id;
  logic signed [31:0] push_value;

  modport source (output valid, command, stack_id, push_value, input ready);
  modport sink   (input valid, command, stack_id, push_value, output ready);
endinterface

interface sds_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] pop_value;
  logic               is_full;
  logic               both_empty;

  modport source (output valid, status, pop_value, is_full, both_empty, input ready);
  modport sink   (input valid, status, pop_value, is_full, both_empty, output ready);
endinterface

`default_nettype wire

// ===== design/sds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sds_front
  import sds_pkg::*;
(
  sds_cmd_if.sink   cmd_i,
  output sds_item_t item_o,
  output logic      item_valid_o,
  input  logic      item_ready_i
);

  sds_act_e act;

  // Decode command and stack code; bad codes go through as rejects.
  always_comb begin
    act = ACT_REJECT;
    unique case (sds_cmd_e'(cmd_i.command))
      CMD_PUSH: begin
        if (cmd_i.stack_id == STACK_LO) act = ACT_PUSH_LO;
        else if (cmd_i.stack_id == STACK_HI) act = ACT_PUSH_HI;
      end
      CMD_POP: begin
        if (cmd_i.stack_id == STACK_LO) act = ACT_POP_LO;
        else if (cmd_i.stack_id == STACK_HI) act = ACT_POP_HI;
      end
      default: act = ACT_REJECT;
    endcase
  end

  assign item_o.act   = act;
  assign item_o.value = cmd_i.push_value;
  assign item_valid_o = cmd_i.valid;
  assign cmd_i.ready  = item_ready_i;

endmodule

`default_nettype wire

// ===== design/sds_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sds_queue
  import sds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sds_item_t wr_item_i,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  output sds_item_t rd_item_o,
  output logic      rd_valid_o,
  input  logic      rd_ready_i
);

  // Two-entry FIFO.
  sds_item_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] level_q;
  logic       wr_fire, rd_fire;

  assign wr_ready_o = (level_q != 2'd2);
  assign rd_valid_o = (level_q != 2'd0);
  assign rd_item_o  = slot_q[rd_ptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (wr_fire) wr_ptr_q <= ~wr_ptr_q;
      if (rd_fire) rd_ptr_q <= ~rd_ptr_q;
      if (wr_fire && !rd_fire) level_q <= level_q + 2'd1;
      else if (rd_fire && !wr_fire) level_q <= level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) slot_q[wr_ptr_q] <= wr_item_i;
  end

endmodule

`default_nettype wire

// ===== design/sds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sds_back
  import sds_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sds_item_t item_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  sds_rsp_if.source rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  sds_bk_state_e    state_q, state_d;
  logic [CW-1:0]    lower_q, lower_d, upper_q, upper_d;
  logic             status_q, pop_ok_q, full_q, empty_q;
  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rdata_q;

  logic          take, room, ok, we, re;
  logic [AW-1:0] addr;
  logic [CW:0]   sum_q, sum_d;
  logic [CW-1:0] lo_pop_c, hi_push_c, hi_pop_c;

  assign item_ready_o = (state_q == BK_IDLE);
  assign take         = item_ready_o && item_valid_i;

  assign sum_q     = {1'b0, lower_q} + {1'b0, upper_q};
  assign sum_d     = {1'b0, lower_d} + {1'b0, upper_d};
  assign room      = (sum_q < (CW+1)'(DEPTH));
  assign lo_pop_c  = lower_q - CW'(1);
  assign hi_push_c = CW'(DEPTH - 1) - upper_q;
  assign hi_pop_c  = CW'(DEPTH) - upper_q;

  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    ok      = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    addr    = lower_q[AW-1:0];
    case (item_i.act)
      ACT_PUSH_LO: begin
        addr = lower_q[AW-1:0];
        if (room) begin
          we = 1'b1; ok = 1'b1; lower_d = lower_q + CW'(1);
        end
      end
      ACT_PUSH_HI: begin
        addr = hi_push_c[AW-1:0];
        if (room) begin
          we = 1'b1; ok = 1'b1; upper_d = upper_q + CW'(1);
        end
      end
      ACT_POP_LO: begin
        addr = lo_pop_c[AW-1:0];
        if (lower_q != '0) begin
          re = 1'b1; ok = 1'b1; lower_d = lo_pop_c;
        end
      end
      ACT_POP_HI: begin
        addr = hi_pop_c[AW-1:0];
        if (upper_q != '0) begin
          re = 1'b1; ok = 1'b1; upper_d = upper_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (item_valid_i) state_d = BK_RESP;
      BK_RESP: if (rsp_o.ready) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      lower_q  <= '0;
      upper_q  <= '0;
      status_q <= 1'b0;
      pop_ok_q <= 1'b0;
      full_q   <= 1'b0;
      empty_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      if (take) begin
        lower_q  <= lower_d;
        upper_q  <= upper_d;
        status_q <= ~ok;
        pop_ok_q <= re;
        full_q   <= (sum_d == (CW+1)'(DEPTH));
        empty_q  <= (lower_d == '0) && (upper_d == '0);
      end
    end
  end

  // Single-port word store, registered read.
  always_ff @(posedge clk_i) begin
    if (take && we) mem_q[addr] <= item_i.value;
    if (take && re) rdata_q <= mem_q[addr];
  end

  assign rsp_o.valid      = (state_q == BK_RESP);
  assign rsp_o.status     = status_q;
  assign rsp_o.pop_value  = pop_ok_q ? $signed(rdata_q) : '0;
  assign rsp_o.is_full    = full_q;
  assign rsp_o.both_empty = empty_q;

endmodule

`default_nettype wire

// ===== design/shared_dual_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                     Handshake
// cmd_i    in   command, stack_id, push_value              valid/ready
// rsp_o    out  status, pop_value, is_full, both_empty     valid/ready
//
// Flow: a transfer on cmd_i lands in a two-entry queue; the back end takes
// it from the queue when idle and registers the result, which it shows on rsp_o.
// The back end takes no new item until rsp_o accepts the last result, as set by
// its execute/respond sequence around the single-port word store.
// Reset: counts clear at once, no clearing pass; words are undefined until pushed.
// Stalls: while rsp_o waits, cmd_i keeps taking transfers until the queue is full.

module shared_dual_stack
  import sds_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sds_cmd_if.sink   cmd_i,
  sds_rsp_if.source rsp_o
);

  sds_item_t fr_item, bk_item;
  logic      fr_valid, fr_ready;
  logic      bk_valid, bk_ready;

  // Front end: decode command and stack code.
  sds_front u_front (
    .cmd_i        (cmd_i),
    .item_o       (fr_item),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready)
  );

  // Decoupling queue between front and back.
  sds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_item_i  (fr_item),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_item_o  (bk_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  // Back end: counts, word store, result register.
  sds_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (bk_item),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .rsp_o        (rsp_o)
  );

  // Back end never takes a new item while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !bk_ready)
    else $error("back end ready while result pending");

  // A transfer out of the queue yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_valid && bk_ready) |=> rsp_o.valid)
    else $error("result missing after queue transfer");

  // Refused items carry no popped word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.pop_value == '0))
    else $error("refused item with nonzero pop value");

  // Full and both-empty cannot hold together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.is_full && rsp_o.both_empty))
    else $error("full and empty flagged together");

endmodule

`default_nettype wire

// ===== verif/shared_dual_stack_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, tracks the two stacks and checks every response
// against the oldest prediction.
module shared_dual_stack_checker
  import sds_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  sds_cmd_if   cmd_i,
  sds_rsp_if   rsp_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   full_refusals_o,
  output int   empty_refusals_o
);

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef struct packed {
    logic             status;
    logic [WordW-1:0] pop_value;
    logic             is_full;
    logic             both_empty;
  } stack_result_t;

  logic [WordW-1:0] words [DEPTH];
  int               lo_cnt;
  int               hi_cnt;
  stack_result_t    result_q [$];

  // One push or pop on the shared array; updates the stack state.
  function automatic stack_result_t apply_stack_op(logic op, logic [1:0] sid,
                                                    logic [WordW-1:0] val);
    stack_result_t r;
    r.status    = ST_REFUSED;
    r.pop_value = '0;
    if (op == CMD_PUSH) begin
      if (lo_cnt + hi_cnt < DEPTH) begin
        if (sid == STACK_LO) begin
          words[lo_cnt] = val;
          lo_cnt++;
          r.status = ST_OK;
        end else if (sid == STACK_HI) begin
          words[DEPTH-1-hi_cnt] = val;
          hi_cnt++;
          r.status = ST_OK;
        end
      end else if (sid == STACK_LO || sid == STACK_HI) begin
        full_refusals_o++;
      end
    end else begin
      if (sid == STACK_LO && lo_cnt > 0) begin
        r.pop_value = words[lo_cnt-1];
        lo_cnt--;
        r.status = ST_OK;
      end else if (sid == STACK_HI && hi_cnt > 0) begin
        r.pop_value = words[DEPTH-hi_cnt];
        hi_cnt--;
        r.status = ST_OK;
      end else if (sid == STACK_LO || sid == STACK_HI) begin
        empty_refusals_o++;
      end
    end
    r.is_full    = (lo_cnt + hi_cnt == DEPTH);
    r.both_empty = (lo_cnt == 0 && hi_cnt == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    int            errs;
    errs = 0;
    if (!rst_ni) begin
      lo_cnt           = 0;
      hi_cnt           = 0;
      result_q.delete();
      fail_cnt_o       <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
      full_refusals_o  = 0;
      empty_refusals_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          $error("response transfer with no prediction waiting");
          errs++;
        end else begin
          want = result_q.pop_front();
          checked_o <= checked_o + 1;
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, rsp_i.status);
            errs++;
          end
          if (rsp_i.pop_value !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, rsp_i.pop_value);
            errs++;
          end
          if (rsp_i.is_full !== want.is_full) begin
            $error("is_full: expected %0b, got %0b", want.is_full, rsp_i.is_full);
            errs++;
          end
          if (rsp_i.both_empty !== want.both_empty) begin
            $error("both_empty: expected %0b, got %0b", want.both_empty,
                   rsp_i.both_empty);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      if (cmd_i.valid && cmd_i.ready)
        result_q.push_back(apply_stack_op(cmd_i.command, cmd_i.stack_id,
                                          cmd_i.push_value));
      pending_o <= result_q.size();
    end
  end

endmodule

// ===== verif/shared_dual_stack_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the shared dual stack. All checking lives in
// shared_dual_stack_checker, which sits beside the block on the same channels.
module shared_dual_stack_test
  import sds_pkg::*;
;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  // Stack codes the block must refuse.
  localparam logic [1:0] STACK_NONE = 2'd0;
  localparam logic [1:0] STACK_BAD  = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sds_cmd_if cmd_ch ();
  sds_rsp_if rsp_ch ();

  int fail_cnt;
  int pending;
  int checked;
  int full_refusals;
  int empty_refusals;

  // Knobs, in percent. stall_pct and rsp_hold are read by the receiver
  // process at the clock edge, so they only change through NBAs.
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic rsp_hold  = 1'b0;
  int   hold_req  = 0;
  int   cycle_cnt = 0;

  always #1 clk_i = ~clk_i;

  shared_dual_stack #(.DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  shared_dual_stack_checker #(.DEPTH(DEPTH)) chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_ch),
    .rsp_i            (rsp_ch),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending),
    .checked_o        (checked),
    .full_refusals_o  (full_refusals),
    .empty_refusals_o (empty_refusals)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random back-pressure, forced low during a long hold-off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off, counted here. The sender keeps offering items,
  // so the internal queue fills and cmd ready must drop.
  initial begin
    int hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rsp_hold <= 1'b0;
      end
    end
  end

  // One transfer on cmd. valid stays high between back-to-back items and is
  // only dropped when a sender gap is drawn.
  task automatic send_op(input sds_cmd_e op, input logic [1:0] sid,
                         input logic [WordW-1:0] val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.stack_id   <= sid;
    cmd_ch.push_value <= val;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // Random item; push_pct biases toward filling or draining the array.
  // About one item in ten carries a bad stack code.
  task automatic random_op(input int push_pct);
    sds_cmd_e         op;
    logic [1:0]       sid;
    logic [WordW-1:0] val;
    int               pick;
    if ($urandom_range(99) < push_pct) op = CMD_PUSH;
    else op = CMD_POP;
    pick = $urandom_range(99);
    if (pick < 45) sid = STACK_LO;
    else if (pick < 90) sid = STACK_HI;
    else if (pick < 95) sid = STACK_NONE;
    else sid = STACK_BAD;
    case ($urandom_range(9))
      0: val = 32'h7fff_ffff;
      1: val = 32'h8000_0000;
      2: val = '0;
      3: val = '1;
      default: val = $urandom();
    endcase
    send_op(op, sid, val);
  endtask

  initial begin
    int seg;
    int push_pct;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_PUSH;
    cmd_ch.stack_id   = STACK_NONE;
    cmd_ch.push_value = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops on both sides, bad codes on both commands,
    // field extremes, and LIFO order across the two ends.
    send_op(CMD_POP,  STACK_LO,   32'h0);
    send_op(CMD_POP,  STACK_HI,   32'hffff_ffff);
    send_op(CMD_PUSH, STACK_NONE, 32'h1234_5678);
    send_op(CMD_PUSH, STACK_BAD,  32'hffff_ffff);
    send_op(CMD_POP,  STACK_NONE, 32'h0);
    send_op(CMD_POP,  STACK_BAD,  32'h0);
    send_op(CMD_PUSH, STACK_LO,   32'h7fff_ffff);
    send_op(CMD_PUSH, STACK_HI,   32'h8000_0000);
    send_op(CMD_PUSH, STACK_LO,   32'hffff_ffff);
    send_op(CMD_PUSH, STACK_HI,   32'h0);
    send_op(CMD_POP,  STACK_BAD,  32'h5555_5555);
    send_op(CMD_POP,  STACK_HI,   32'haaaa_aaaa);
    send_op(CMD_POP,  STACK_LO,   32'h0);
    send_op(CMD_POP,  STACK_HI,   32'h0);
    send_op(CMD_POP,  STACK_LO,   32'h0);
    send_op(CMD_POP,  STACK_LO,   32'h0);

    // Random phases: none, sender gaps, receiver stalls, both light.
    // Each phase cycles fill / drain / balanced segments so both stacks
    // hit full and empty many times with the tops meeting anywhere.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 63; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 63; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      if (ph == 0 || ph == 3) hold_req <= hold_req + 1;
      for (seg = 0; seg < 6; seg++) begin
        case (seg % 3)
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        repeat (60) random_op(push_pct);
      end
    end

    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d responses over four handshake phases with a long hold-off",
             checked);
    $display("Pushes refused at full: %0d, pops refused on an empty stack: %0d",
             full_refusals, empty_refusals);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sds_pkg.sv
design/sds_if.sv
design/sds_front.sv
design/sds_queue.sv
design/sds_back.sv
design/shared_dual_stack.sv
verif/shared_dual_stack_checker.sv
verif/shared_dual_stack_test.sv
